// ----- sv/ultrasonic_echo_ranger_defines.svh -----
// Assertion macros used by the ultrasonic echo ranger sequencer RTL.
`ifndef ULTRASONIC_ECHO_RANGER_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_DEFINES_SVH

// Same-edge implication, checked outside reset.
`define UER_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-edge implication, checked outside reset.
`define UER_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/uer_pkg.sv -----
// Types, codes and constants of the ultrasonic echo ranger.
package uer_pkg;

    localparam int TICK_W  = 16;
    localparam int TRIG_W  = 10;
    localparam int DIST_W  = 24;
    localparam int IDX_W   = 3;
    localparam int OUT_W   = 48;
    localparam int FRAC_SH = 8;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_WAIT_LOW  = 3'd1,
        PH_TRIG      = 3'd2,
        PH_WAIT_RISE = 3'd3,
        PH_MEASURE   = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_STUCK   = 2'd1,
        ST_NO_RISE = 2'd2,
        ST_TIMEOUT = 2'd3
    } status_t;

    typedef enum logic [IDX_W-1:0] {
        REG_IDLE_TIMEOUT = 3'd0,
        REG_RISE_TIMEOUT = 3'd1,
        REG_ECHO_TIMEOUT = 3'd2,
        REG_TRIG_WIDTH   = 3'd3,
        REG_DIST_SCALE   = 3'd4
    } reg_idx_t;

    localparam logic [TICK_W-1:0] IDLE_TIMEOUT_RST = 16'd30000;
    localparam logic [TICK_W-1:0] RISE_TIMEOUT_RST = 16'd60000;
    localparam logic [TICK_W-1:0] ECHO_TIMEOUT_RST = 16'd40000;
    localparam logic [TRIG_W-1:0] TRIG_WIDTH_RST   = 10'd50;
    localparam logic [TICK_W-1:0] DIST_SCALE_RST   = 16'd1124;

    typedef struct packed {
        logic [TICK_W-1:0] idle_timeout_us;
        logic [TICK_W-1:0] rise_timeout_us;
        logic [TICK_W-1:0] echo_timeout_us;
        logic [TRIG_W-1:0] trigger_width_us;
    } timing_cfg_t;

    typedef struct packed {
        logic              trigger_level;
        logic              busy_res;
        logic              done_res;
        status_t           status;
        logic [TICK_W-1:0] pulse_width_us;
    } tick_res_t;

    function automatic logic [TICK_W-1:0] inc_sat(input logic [TICK_W-1:0] v);
        inc_sat = (v == {TICK_W{1'b1}}) ? v : v + TICK_W'(1);
    endfunction

endpackage

// ----- sv/uer_fsm.sv -----
// Measurement sequencer: phase, tick counter and per-tick result register.
`include "ultrasonic_echo_ranger_defines.svh"

module uer_fsm (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_accept,
    input  logic               start_request,
    input  logic               echo_level,
    input  uer_pkg::timing_cfg_t cfg,
    output uer_pkg::tick_res_t res_reg
);
    import uer_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [TICK_W-1:0] count_reg, count_next;
    logic [TICK_W-1:0] count_inc;
    logic              done_next;
    status_t           status_next;
    logic [TICK_W-1:0] pulse_next;
    tick_res_t         res_next;

    assign count_inc = inc_sat(count_reg);

    // Next state, counter and held status
    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        status_next = res_reg.status;
        pulse_next  = res_reg.pulse_width_us;
        done_next   = 1'b0;
        unique case (phase_reg)
            PH_WAIT_LOW: begin
                if (!echo_level) begin
                    phase_next = PH_TRIG;
                    count_next = TICK_W'(1);
                end else begin
                    count_next = count_inc;
                    if (count_inc >= cfg.idle_timeout_us) begin
                        phase_next  = PH_IDLE;
                        count_next  = '0;
                        status_next = ST_STUCK;
                        pulse_next  = '0;
                        done_next   = 1'b1;
                    end
                end
            end
            PH_TRIG: begin
                if (count_reg >= TICK_W'(cfg.trigger_width_us)) begin
                    phase_next = PH_WAIT_RISE;
                    count_next = '0;
                end else begin
                    count_next = count_inc;
                end
            end
            PH_WAIT_RISE: begin
                if (echo_level) begin
                    phase_next = PH_MEASURE;
                    count_next = TICK_W'(1);
                    if (TICK_W'(1) >= cfg.echo_timeout_us) begin
                        phase_next  = PH_IDLE;
                        count_next  = '0;
                        status_next = ST_TIMEOUT;
                        pulse_next  = '0;
                        done_next   = 1'b1;
                    end
                end else begin
                    count_next = count_inc;
                    if (count_inc >= cfg.rise_timeout_us) begin
                        phase_next  = PH_IDLE;
                        count_next  = '0;
                        status_next = ST_NO_RISE;
                        pulse_next  = '0;
                        done_next   = 1'b1;
                    end
                end
            end
            PH_MEASURE: begin
                if (!echo_level) begin
                    phase_next  = PH_IDLE;
                    count_next  = '0;
                    status_next = ST_OK;
                    pulse_next  = count_reg;
                    done_next   = 1'b1;
                end else begin
                    count_next = count_inc;
                    if (count_inc >= cfg.echo_timeout_us) begin
                        phase_next  = PH_IDLE;
                        count_next  = '0;
                        status_next = ST_TIMEOUT;
                        pulse_next  = '0;
                        done_next   = 1'b1;
                    end
                end
            end
            default: begin
                phase_next = PH_IDLE;
                if (start_request) begin
                    phase_next = PH_WAIT_LOW;
                    count_next = '0;
                end
            end
        endcase
    end

    // Result fields for this tick
    always_comb begin
        res_next.trigger_level  = (phase_next == PH_TRIG);
        res_next.busy_res       = (phase_next != PH_IDLE);
        res_next.done_res       = done_next;
        res_next.status         = status_next;
        res_next.pulse_width_us = pulse_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            res_reg   <= '0;
        end else if (in_accept) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            res_reg   <= res_next;
        end
    end

    `UER_ASSERT_NOW(a_done_not_busy, res_reg.done_res, !res_reg.busy_res,
        "finished measurement still flagged busy")
    `UER_ASSERT_NOW(a_trig_phase, res_reg.trigger_level, phase_reg == PH_TRIG,
        "trigger high outside trigger phase")
    `UER_ASSERT_NOW(a_fail_zero, res_reg.done_res && (res_reg.status != ST_OK),
        res_reg.pulse_width_us == '0, "failed measurement reports a pulse width")
    `UER_ASSERT_NEXT(a_idle_hold, in_accept && (phase_reg == PH_IDLE) && !start_request,
        phase_reg == PH_IDLE, "left idle without a start request")

endmodule

// ----- sv/uer_dist.sv -----
// Distance multiply and output register of the result stream.
module uer_dist (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      res_valid,
    input  uer_pkg::tick_res_t        res,
    input  logic [uer_pkg::TICK_W-1:0] scale_q16,
    output logic                      res_ready,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [uer_pkg::OUT_W-1:0] m_tdata
);
    import uer_pkg::*;

    logic                   m_valid_reg, m_valid_next;
    logic [2*TICK_W-1:0]    product;
    logic [DIST_W-1:0]      dist_q8;
    logic [OUT_W-1:0]       data_reg;

    assign res_ready = !m_valid_reg || m_tready;
    assign product   = (2*TICK_W)'(res.pulse_width_us) * (2*TICK_W)'(scale_q16);
    assign dist_q8   = product[FRAC_SH +: DIST_W];

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            data_reg <= {3'b000, dist_q8, res.pulse_width_us, res.status,
                         res.done_res, res.busy_res, res.trigger_level};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = data_reg;

endmodule

// ----- sv/ultrasonic_echo_ranger.sv -----
// Ultrasonic echo ranger: takes one sample per microsecond tick and returns one result per
// tick, with a full transaction accepted every clock cycle while the result side keeps up.
// The sequencer register stage updates phase, counter and status, then the 16x16 distance
// multiply feeds the output register. A stalled output holds one result in each stage before
// input is back-pressured. Configuration writes are always accepted and are meant to be
// issued while no measurement result is outstanding.
module ultrasonic_echo_ranger (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] start_request, [1] echo_level
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [0] trigger_level, [1] busy_res, [2] done_res,
                                   // [4:3] status, [20:5] pulse_width_us, [44:21] distance_q8
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import uer_pkg::*;

    timing_cfg_t       timing_reg;
    logic [TICK_W-1:0] scale_reg;
    logic              in_accept;
    logic              res_valid_reg, res_valid_next;
    logic              res_ready;
    tick_res_t         res;

    assign cfg_ready = 1'b1;

    // Register file; unknown indices are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timing_reg.idle_timeout_us  <= IDLE_TIMEOUT_RST;
            timing_reg.rise_timeout_us  <= RISE_TIMEOUT_RST;
            timing_reg.echo_timeout_us  <= ECHO_TIMEOUT_RST;
            timing_reg.trigger_width_us <= TRIG_WIDTH_RST;
            scale_reg                   <= DIST_SCALE_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_IDLE_TIMEOUT: timing_reg.idle_timeout_us  <= cfg_data;
                REG_RISE_TIMEOUT: timing_reg.rise_timeout_us  <= cfg_data;
                REG_ECHO_TIMEOUT: timing_reg.echo_timeout_us  <= cfg_data;
                REG_TRIG_WIDTH:   timing_reg.trigger_width_us <= cfg_data[TRIG_W-1:0];
                REG_DIST_SCALE:   scale_reg                   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready  = !res_valid_reg || res_ready;
    assign in_accept = s_tvalid && s_tready;

    always_comb begin
        res_valid_next = res_valid_reg;
        if (in_accept) begin
            res_valid_next = 1'b1;
        end else if (res_ready) begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
        end
    end

    uer_fsm u_fsm (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_accept     (in_accept),
        .start_request (s_tdata[0]),
        .echo_level    (s_tdata[1]),
        .cfg           (timing_reg),
        .res_reg       (res)
    );

    uer_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid_reg),
        .res       (res),
        .scale_q16 (scale_reg),
        .res_ready (res_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
